FILE: src/coprocessor_mailbox_responder_defines.svh
// Assertion helpers shared by the responder RTL.
// Both sample on clock and are disabled while reset is high.
`ifndef COPROCESSOR_MAILBOX_RESPONDER_DEFINES_SVH
`define COPROCESSOR_MAILBOX_RESPONDER_DEFINES_SVH

// Same-cycle implication.
`define CMR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mailbox responder: same-cycle check failed");

// Next-cycle implication.
`define CMR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mailbox responder: next-cycle check failed");

`endif

FILE: src/cmr_pkg.sv
package cmr_pkg;

   // Client endpoint window
   localparam int CLIENT_ENDPOINTS = 32;
   localparam int CLIENT_IDX_W     = $clog2(CLIENT_ENDPOINTS);
   localparam logic [7:0] CLIENT_BASE  = 8'd32;
   localparam logic [7:0] CLIENT_LIMIT = 8'(32 + CLIENT_ENDPOINTS);
   localparam int MAP_W     = 64;
   localparam int MAP_IDX_W = $clog2(MAP_W);

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VERSION = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VERSION = 1'b1;
   localparam logic [15:0] MIN_VERSION_RESET = 16'd11;
   localparam logic [15:0] MAX_VERSION_RESET = 16'd12;

   // Request modes
   localparam logic [1:0] MODE_RECV  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_SEND  = 2'd2;
   localparam logic [1:0] MODE_WAKE  = 2'd3;

   // Response kinds
   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_MSG     = 2'd1;
   localparam logic [1:0] KIND_DELIVER = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_UNHANDLED = 2'd2;

   // Endpoints
   localparam logic [7:0] EP_MGMT     = 8'd0;
   localparam logic [7:0] EP_CRASHLOG = 8'd1;
   localparam logic [7:0] EP_DEBUG    = 8'd3;
   localparam logic [7:0] EP_IOREPORT = 8'd4;

   // Message types
   localparam logic [7:0] MSG_HELLO     = 8'd1;
   localparam logic [7:0] MSG_HELLO_ACK = 8'd2;
   localparam logic [7:0] MSG_STARTEP   = 8'd5;
   localparam logic [7:0] MSG_PWR       = 8'd6;
   localparam logic [7:0] MSG_PWR_ACK   = 8'd7;
   localparam logic [7:0] MSG_EPMAP     = 8'd8;
   localparam logic [7:0] MSG_BUFREQ    = 8'd1;
   localparam logic [7:0] PWR_ON        = 8'h20;

   // Start bits carried by a job: [0] crashlog, [1] debug, [2] ioreport
   localparam int START_W = 3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         out_endpoint;
      logic [63:0]        out_data;
      logic [1:0]         status;
      logic [7:0]         power_state;
      logic [START_W-1:0] starts;
   } job_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_endpoint;
      logic [63:0] out_data;
      logic [1:0]  status;
      logic [7:0]  power_state;
      logic        last;
   } rsp_type;

   // Outgoing word: type in bits 59..52 over a 52-bit body
   function automatic logic [63:0] msg_word(input logic [7:0] msg_type,
                                            input logic [51:0] body);
      msg_word = {4'b0, msg_type, body};
   endfunction

   function automatic logic [63:0] start_word(input logic [7:0] ep);
      start_word = msg_word(MSG_STARTEP, {12'b0, ep, 32'd2});
   endfunction

endpackage

FILE: src/cmr_req_if.sv
interface cmr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  in_endpoint;
   logic [63:0] in_data;

   modport source (output valid, output mode, output in_endpoint, output in_data,
                   input ready);
   modport sink   (input valid, input mode, input in_endpoint, input in_data,
                   output ready);
endinterface

FILE: src/cmr_rsp_if.sv
interface cmr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_endpoint;
   logic [63:0] out_data;
   logic [1:0]  status;
   logic [7:0]  power_state;
   logic        last;

   modport source (output valid, output kind, output out_endpoint, output out_data,
                   output status, output power_state, output last, input ready);
   modport sink   (input valid, input kind, input out_endpoint, input out_data,
                   input status, input power_state, input last, output ready);
endinterface

FILE: src/cmr_front.sv
module cmr_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [cmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                    csr_write_data,
   cmr_req_if.sink                        req,
   input  logic                           queue_full,
   output logic                           push,
   output cmr_pkg::job_type               job
);
   import cmr_pkg::*;

   logic [15:0]                 min_version_ff;
   logic [15:0]                 max_version_ff;
   logic [7:0]                  power_ff, power_in;
   logic [MAP_W-1:0]            map_ff, map_in;
   logic [CLIENT_ENDPOINTS-1:0] client_ff, client_in;

   logic [7:0]              ep;
   logic [63:0]             data;
   logic [7:0]              msg_type;
   logic [15:0]             hello_min, hello_max, hello_ver;
   logic                    hello_bad;
   logic [2:0]              map_base;
   logic                    map_last;
   logic                    is_client;
   logic [7:0]              client_off;
   logic [CLIENT_IDX_W-1:0] client_idx;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   assign ep         = req.in_endpoint;
   assign data       = req.in_data;
   assign msg_type   = data[59:52];
   assign hello_min  = data[15:0];
   assign hello_max  = data[31:16];
   assign hello_bad  = (hello_min > max_version_ff) || (hello_max < min_version_ff);
   assign hello_ver  = (hello_max < max_version_ff) ? hello_max : max_version_ff;
   assign map_base   = data[34:32];
   assign map_last   = data[51];
   assign is_client  = (ep >= CLIENT_BASE) && (ep < CLIENT_LIMIT);
   assign client_off = ep - CLIENT_BASE;
   assign client_idx = client_off[CLIENT_IDX_W-1:0];

   always_comb begin
      power_in  = power_ff;
      map_in    = map_ff;
      client_in = client_ff;

      job.kind         = KIND_STATUS;
      job.out_endpoint = EP_MGMT;
      job.out_data     = 64'd0;
      job.status       = STATUS_OK;
      job.starts       = '0;

      case (req.mode)
         MODE_RECV: begin
            if (ep == EP_MGMT) begin
               case (msg_type)
                  MSG_HELLO: begin
                     if (hello_bad) begin
                        job.status = STATUS_INVALID;
                     end else begin
                        job.kind     = KIND_MSG;
                        job.out_data = msg_word(MSG_HELLO_ACK,
                                                {20'b0, hello_ver, hello_ver});
                     end
                  end
                  MSG_PWR_ACK: begin
                     power_in = data[7:0];
                  end
                  MSG_EPMAP: begin
                     if (map_base == 3'd0) begin
                        map_in[31:0] = map_ff[31:0] | data[31:0];
                     end else if (map_base == 3'd1) begin
                        map_in[63:32] = map_ff[63:32] | data[31:0];
                     end
                     job.kind     = KIND_MSG;
                     job.out_data = msg_word(MSG_EPMAP,
                                             {map_last, 16'b0, map_base, 31'b0, !map_last});
                     if (map_last) begin
                        job.starts = {map_in[EP_IOREPORT[MAP_IDX_W-1:0]],
                                      map_in[EP_DEBUG[MAP_IDX_W-1:0]],
                                      map_in[EP_CRASHLOG[MAP_IDX_W-1:0]]};
                     end
                  end
                  default: begin
                     job.status = STATUS_UNHANDLED;
                  end
               endcase
            end else if (ep == EP_CRASHLOG || ep == EP_IOREPORT) begin
               if (msg_type != MSG_BUFREQ) begin
                  job.status = STATUS_UNHANDLED;
               end else if (data[41:0] == 42'd0) begin
                  job.kind         = KIND_MSG;
                  job.out_endpoint = ep;
                  job.out_data     = msg_word(MSG_BUFREQ, {data[51:44], 44'b0});
               end
            end else if (is_client && client_ff[client_idx]) begin
               job.kind         = KIND_DELIVER;
               job.out_endpoint = ep;
               job.out_data     = data;
            end else begin
               job.status = STATUS_UNHANDLED;
            end
         end
         MODE_START: begin
            if (is_client && map_ff[ep[MAP_IDX_W-1:0]]) begin
               client_in[client_idx] = 1'b1;
               job.kind     = KIND_MSG;
               job.out_data = start_word(ep);
            end else begin
               job.status = STATUS_INVALID;
            end
         end
         MODE_SEND: begin
            job.kind         = KIND_MSG;
            job.out_endpoint = ep;
            job.out_data     = data;
         end
         MODE_WAKE: begin
            job.kind     = KIND_MSG;
            job.out_data = msg_word(MSG_PWR, {44'b0, PWR_ON});
         end
         default: begin
            job.status = STATUS_UNHANDLED;
         end
      endcase

      job.power_state = power_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_version_ff <= MIN_VERSION_RESET;
         max_version_ff <= MAX_VERSION_RESET;
         power_ff       <= '0;
         map_ff         <= '0;
         client_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MIN_VERSION: min_version_ff <= csr_write_data;
               CSR_MAX_VERSION: max_version_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (push) begin
            power_ff  <= power_in;
            map_ff    <= map_in;
            client_ff <= client_in;
         end
      end
   end

`include "coprocessor_mailbox_responder_defines.svh"

   `CMR_ASSERT_NEXT(a_client_only_grows, 1'b1, (client_ff & $past(client_ff)) == $past(client_ff))
   `CMR_ASSERT_NEXT(a_map_only_grows, 1'b1, (map_ff & $past(map_ff)) == $past(map_ff))
   `CMR_ASSERT_IMPL(a_starts_from_map_echo, push && (job.starts != '0), (job.kind == KIND_MSG) && (job.out_data[59:52] == MSG_EPMAP) && job.out_data[51])

endmodule

FILE: src/cmr_queue.sv
module cmr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmr_pkg::job_type push_job,
   input  logic             pop,
   output cmr_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);
   import cmr_pkg::*;

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: src/cmr_back.sv
module cmr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  cmr_pkg::job_type head_job,
   output logic             pop,
   cmr_rsp_if.source        rsp
);
   import cmr_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [START_W-1:0]  pending_ff, pending_in;
   logic [7:0]          power_ff, power_in;
   logic                advance;
   logic [7:0]          start_ep;
   logic [START_W-1:0]  pending_left;

   assign advance = !rsp_valid_ff || rsp.ready;

   // Pick the next start in order crashlog, debug, ioreport
   always_comb begin
      pending_left = pending_ff;
      if (pending_ff[0]) begin
         start_ep        = EP_CRASHLOG;
         pending_left[0] = 1'b0;
      end else if (pending_ff[1]) begin
         start_ep        = EP_DEBUG;
         pending_left[1] = 1'b0;
      end else begin
         start_ep        = EP_IOREPORT;
         pending_left[2] = 1'b0;
      end
   end

   always_comb begin
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pending_in   = pending_ff;
      power_in     = power_ff;
      if (advance) begin
         if (pending_ff != '0) begin
            rsp_valid_in        = 1'b1;
            rsp_in.kind         = KIND_MSG;
            rsp_in.out_endpoint = EP_MGMT;
            rsp_in.out_data     = start_word(start_ep);
            rsp_in.status       = STATUS_OK;
            rsp_in.power_state  = power_ff;
            rsp_in.last         = (pending_left == '0);
            pending_in          = pending_left;
         end else if (!empty) begin
            pop                 = 1'b1;
            rsp_valid_in        = 1'b1;
            rsp_in.kind         = head_job.kind;
            rsp_in.out_endpoint = head_job.out_endpoint;
            rsp_in.out_data     = head_job.out_data;
            rsp_in.status       = head_job.status;
            rsp_in.power_state  = head_job.power_state;
            rsp_in.last         = (head_job.starts == '0);
            pending_in          = head_job.starts;
            power_in            = head_job.power_state;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      power_ff <= power_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = rsp_ff.kind;
   assign rsp.out_endpoint = rsp_ff.out_endpoint;
   assign rsp.out_data     = rsp_ff.out_data;
   assign rsp.status       = rsp_ff.status;
   assign rsp.power_state  = rsp_ff.power_state;
   assign rsp.last         = rsp_ff.last;

`include "coprocessor_mailbox_responder_defines.svh"

   `CMR_ASSERT_IMPL(a_pop_only_when_drained, pop, pending_ff == '0)
   `CMR_ASSERT_IMPL(a_pending_has_result, pending_ff != '0, rsp_valid_ff && !rsp_ff.last)
   `CMR_ASSERT_IMPL(a_last_ends_item, rsp_valid_ff && rsp_ff.last, pending_ff == '0)

endmodule

FILE: src/coprocessor_mailbox_responder.sv
// Coprocessor mailbox responder.
// req_bus carries one request per valid/ready handshake: a received mailbox
// message, a client start, a send to an endpoint or a wake request.
// rsp_bus returns one to four responses per request, in order; last marks
// the final one. csr_write_enable/csr_index/csr_write_data set min_version
// (index 0) and max_version (index 1); write them only while idle.
// Throughput: one request per cycle enters while the four-entry job queue
// has room; responses leave at one per cycle while rsp_bus is ready, and a
// request has one response, or up to four for a final map chunk.
// A taken request is written into the job queue, then loaded into the output
// register once it reaches the queue head and the output can advance.
// Reset (synchronous): clears the power state, endpoint map, client
// registrations, queue and output; versions return to 11 and 12.
// A stalled rsp_bus holds its response; the queue keeps taking requests
// until it fills, then req_bus.ready drops.
module coprocessor_mailbox_responder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [cmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_write_data,
   cmr_req_if.sink                         req_bus,
   cmr_rsp_if.source                       rsp_bus
);
   import cmr_pkg::*;

   // Front side: classify, update state, build one job per request
   logic    push;
   job_type push_job;
   // Queue status and head
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   job_type head_job;

   cmr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_bus),
      .queue_full       (queue_full),
      .push             (push),
      .job              (push_job)
   );

   // Decouple: front advances while the back end is stalled, until the queue fills
   cmr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // Back side: expand each job into its responses, one per cycle while rsp_bus is ready
   cmr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (queue_empty),
      .head_job (head_job),
      .pop      (pop),
      .rsp      (rsp_bus)
   );

endmodule
